// ----- sv/wc3_pkg.sv -----
// Package for the 3x3 window convolution unit: payload types, sizes and helpers.
// Used by every module of the block but wc3_ram; depends on nothing.
package wc3_pkg;

   localparam int MAX_WIDTH_DEF   = 2048;
   localparam int KERNEL_SIZE_DEF = 3;
   localparam int MAX_HEIGHT      = 2048;
   localparam int DIM_W           = 12;
   localparam int COEF_ROW_W      = 48;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_TOP    = 3'd2;
   localparam logic [2:0] REG_MID    = 3'd3;
   localparam logic [2:0] REG_BOT    = 3'd4;

   typedef struct packed {
      logic       kind;
      logic [7:0] intensity;
   } req_type;

   typedef struct packed {
      logic [7:0] filtered;
      logic       row_end;
      logic       frame_end;
   } rsp_type;

   // One classified pixel handed from the front to the back. The position
   // flags belong to the result that this pixel completes, if any.
   typedef struct packed {
      logic [7:0]  px;
      logic [7:0]  mid;
      logic [7:0]  top;
      logic        emit;
      logic        row_end;
      logic        frame_end;
      logic        top_ok;
      logic        bot_ok;
      logic        left_ok;
      logic        right_ok;
   } job_type;

   function automatic logic signed [15:0] coef_at(input logic [47:0] row, input int pos);
      coef_at = row[16*pos +: 16];
   endfunction

endpackage

// ----- sv/wc3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wc3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

// ----- sv/wc3_front.sv -----
// Front end: classifies requests, tracks the input and output raster positions
// and runs the line buffers. Depends on wc3_pkg and wc3_ram.
module wc3_front import wc3_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [DIM_W-1:0] eff_w,
   input  logic [DIM_W-1:0] eff_h,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             job_valid,
   output job_type          job_data,
   input  logic             job_room
);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);

   logic [CW-1:0] in_column_ff, in_column_in;
   logic [11:0]   in_row_ff, in_row_in;
   logic [11:0]   out_column_ff, out_column_in;
   logic [11:0]   out_row_ff, out_row_in;
   logic          s1_valid_ff;
   logic [7:0]    s1_px_ff;
   logic          s1_emit_ff;
   logic          s1_rend_ff, s1_fend_ff;
   logic [3:0]    s1_ok_ff;
   logic [AW-1:0] s1_idx_ff;
   logic [7:0]    mid_q, top_q;

   logic        accept, pixels_done, take, emit;
   logic [CW-1:0] col_a;
   logic [11:0] row_a;
   logic [11:0] oc, orow;
   logic        rend, fend;
   logic [3:0]  ok;
   logic [AW-1:0] idx;
   logic [7:0]  px;

   assign req_stall   = !job_room;
   assign accept      = req_valid && !req_stall;
   assign pixels_done = (in_row_ff >= 12'(eff_h));
   assign take        = accept && !(req_data.kind && !pixels_done);
   assign px          = pixels_done ? 8'd0 : req_data.intensity;

   always_comb begin
      col_a = in_column_ff;
      row_a = in_row_ff;
      if (DIM_W'(in_column_ff) >= eff_w) begin
         col_a = '0;
         if (row_a != 12'd4095) row_a = row_a + 12'd1;
      end
      idx  = (col_a < CW'(MAX_WIDTH)) ? col_a[AW-1:0] : AW'(MAX_WIDTH - 1);
      emit = (row_a >= 12'd2) || (row_a == 12'd1 && col_a >= CW'(1));
      in_column_in = col_a + CW'(1);
      in_row_in    = row_a;
      if (DIM_W'(col_a) + DIM_W'(1) >= eff_w) begin
         in_column_in = '0;
         if (row_a != 12'd4095) in_row_in = row_a + 12'd1;
      end
      // The output position is kept here so that a frame end restarts the
      // input counters on the very request that completes the frame.
      oc   = out_column_ff;
      orow = out_row_ff;
      if (oc >= eff_w) begin
         oc   = '0;
         orow = orow + 12'd1;
      end
      rend = (oc + 12'd1 >= eff_w);
      fend = rend && (orow + 12'd1 >= eff_h);
      ok   = {orow >= 12'd1, orow + 12'd1 < eff_h, oc >= 12'd1, oc + 12'd1 < eff_w};
      out_column_in = out_column_ff;
      out_row_in    = out_row_ff;
      if (emit) begin
         if (fend) begin
            out_column_in = '0;
            out_row_in    = '0;
            in_column_in  = '0;
            in_row_in     = '0;
         end else if (rend) begin
            out_column_in = '0;
            out_row_in    = orow + 12'd1;
         end else begin
            out_column_in = oc + 12'd1;
            out_row_in    = orow;
         end
      end
   end

   // Registered reads of both lines; a read of the entry that stage 1 writes
   // is bypassed from stage 1.
   wc3_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid (
      .clock, .wr_en(s1_valid_ff), .wr_addr(s1_idx_ff), .wr_data(s1_px_ff),
      .rd_en(take), .rd_addr(idx), .rd_data(mid_q));
   logic [7:0] mid_fix, top_fix;
   logic       byp_ff;
   logic [7:0] byp_mid_ff, byp_px_ff;
   assign mid_fix = byp_ff ? byp_px_ff : mid_q;
   assign top_fix = byp_ff ? byp_mid_ff : top_q;
   wc3_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_top (
      .clock, .wr_en(s1_valid_ff), .wr_addr(s1_idx_ff), .wr_data(mid_fix),
      .rd_en(take), .rd_addr(idx), .rd_data(top_q));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         byp_ff        <= 1'b0;
      end else begin
         s1_valid_ff <= take;
         if (take) begin
            byp_ff        <= s1_valid_ff && (s1_idx_ff == idx);
            in_column_ff  <= in_column_in;
            in_row_ff     <= in_row_in;
            out_column_ff <= out_column_in;
            out_row_ff    <= out_row_in;
         end
      end
      if (take) begin
         s1_px_ff   <= px;
         s1_emit_ff <= emit;
         s1_rend_ff <= rend;
         s1_fend_ff <= fend;
         s1_ok_ff   <= ok;
         s1_idx_ff  <= idx;
         byp_px_ff  <= s1_px_ff;
         byp_mid_ff <= mid_fix;
      end
   end

   assign job_valid          = s1_valid_ff;
   assign job_data.px        = s1_px_ff;
   assign job_data.mid       = mid_fix;
   assign job_data.top       = top_fix;
   assign job_data.emit      = s1_emit_ff;
   assign job_data.row_end   = s1_rend_ff;
   assign job_data.frame_end = s1_fend_ff;
   assign job_data.top_ok    = s1_ok_ff[3];
   assign job_data.bot_ok    = s1_ok_ff[2];
   assign job_data.left_ok   = s1_ok_ff[1];
   assign job_data.right_ok  = s1_ok_ff[0];
endmodule

// ----- sv/wc3_fifo.sv -----
// Short queue between the front and back of the convolution unit.
// Depends on wc3_pkg.
module wc3_fifo import wc3_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    room,
   output logic    pop_valid,
   output job_type pop_data,
   input  logic    pop
);
   job_type     mem_ff [4];
   logic [1:0]  wp_ff, rp_ff;
   logic [2:0]  cnt_ff;

   // Two slots are held back for the requests already in the front pipeline.
   assign room      = (cnt_ff <= 3'd1);
   assign pop_valid = (cnt_ff != 3'd0);
   assign pop_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop)  rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end
endmodule

// ----- sv/wc3_back.sv -----
// Back end: shifts the 3x3 window, masks the border, multiplies, sums, shifts
// and saturates. Depends on wc3_pkg.
module wc3_back import wc3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COEF_ROW_W-1:0] coef_top,
   input  logic [COEF_ROW_W-1:0] coef_mid,
   input  logic [COEF_ROW_W-1:0] coef_bot,
   input  logic                  job_valid,
   input  job_type               job_data,
   output logic                  job_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);
   logic [7:0]  win_ff [3][3];
   logic        p1_valid_ff, p2_valid_ff, o_valid_ff;
   logic signed [24:0] prod_ff [3][3];
   logic        p1_rend_ff, p1_fend_ff, p2_rend_ff, p2_fend_ff;
   logic signed [28:0] sum_ff;
   rsp_type     o_ff;

   logic adv, go;
   logic rend, fend;
   logic rowok [3];
   logic colok [3];
   logic [7:0] nw [3][3];
   logic signed [28:0] sum_c;
   logic [47:0] rowc [3];

   // The pipeline moves whenever the result register is free or being taken.
   assign adv     = !(o_valid_ff && rsp_stall);
   assign job_pop = job_valid && adv;
   assign go      = job_pop && job_data.emit;

   always_comb begin
      rend = job_data.row_end;
      fend = job_data.frame_end;
      rowok[0] = job_data.top_ok;
      rowok[1] = 1'b1;
      rowok[2] = job_data.bot_ok;
      colok[0] = job_data.left_ok;
      colok[1] = 1'b1;
      colok[2] = job_data.right_ok;
      for (int i = 0; i < 3; i++) begin
         nw[i][0] = win_ff[i][1];
         nw[i][1] = win_ff[i][2];
      end
      nw[0][2] = job_data.top;
      nw[1][2] = job_data.mid;
      nw[2][2] = job_data.px;
      rowc[0] = coef_top;
      rowc[1] = coef_mid;
      rowc[2] = coef_bot;
      sum_c = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sum_c = sum_c + 29'(prod_ff[i][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         o_valid_ff    <= 1'b0;
      end else if (adv) begin
         if (job_pop) win_ff <= nw;
         p1_valid_ff <= go;
         p2_valid_ff <= p1_valid_ff;
         o_valid_ff  <= p2_valid_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= (rowok[i] && colok[j]) ?
                  $signed({1'b0, nw[i][j]}) * coef_at(rowc[i], j) : 25'sd0;
            end
         end
         p1_rend_ff <= rend;
         p1_fend_ff <= fend;
         sum_ff     <= sum_c;
         p2_rend_ff <= p1_rend_ff;
         p2_fend_ff <= p1_fend_ff;
         o_ff.row_end   <= p2_rend_ff;
         o_ff.frame_end <= p2_fend_ff;
         if (sum_ff < 0)                       o_ff.filtered <= 8'd0;
         else if (sum_ff[27:8] > 20'd255)      o_ff.filtered <= 8'd255;
         else                                  o_ff.filtered <= sum_ff[15:8];
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_ff;
endmodule

// ----- sv/window_convolution_3x3_unit.sv -----
// 3x3 window convolution unit with two line buffers.
// Throughput: one request per cycle while req_stall is low, i.e. while the queue
// has room. A result passes from the accepting edge of the request that completes
// its window through the line-buffer read stage, the queue and 3 math stages. The
// first result needs one row plus two pixels of input, set by the line buffers.
// Synchronous active-high reset clears counters, window and valid flags and loads
// the configuration defaults; line memories and data registers are not cleared.
module window_convolution_3x3_unit import wc3_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   logic [11:0] width_ff, height_ff;
   logic [47:0] top_ff, mid_ff, bot_ff;
   logic [DIM_W-1:0] eff_w, eff_h;
   logic [2:0] reg_sel;
   logic wr;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[5:3];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 12'd480;
         top_ff    <= '0;
         mid_ff    <= 48'd256;
         bot_ff    <= '0;
      end else if (wr) begin
         case (reg_sel)
            REG_WIDTH:  width_ff  <= csr_pwdata[11:0];
            REG_HEIGHT: height_ff <= csr_pwdata[11:0];
            REG_TOP:    top_ff    <= csr_pwdata[47:0];
            REG_MID:    mid_ff    <= csr_pwdata[47:0];
            REG_BOT:    bot_ff    <= csr_pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_WIDTH:  csr_prdata = {52'd0, width_ff};
         REG_HEIGHT: csr_prdata = {52'd0, height_ff};
         REG_TOP:    csr_prdata = {16'd0, top_ff};
         REG_MID:    csr_prdata = {16'd0, mid_ff};
         REG_BOT:    csr_prdata = {16'd0, bot_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign eff_w = (width_ff == 12'd0) ? DIM_W'(1) :
                  ({1'b0, width_ff} > 13'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ff;
   assign eff_h = (height_ff == 12'd0) ? DIM_W'(1) :
                  ({1'b0, height_ff} > 13'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ff;

   logic job_valid, job_room, q_valid, q_pop;
   job_type job_data, q_data;

   wc3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock, .reset, .eff_w, .eff_h,
      .req_valid, .req_stall, .req_data,
      .job_valid, .job_data, .job_room);

   wc3_fifo u_fifo (
      .clock, .reset, .push(job_valid), .push_data(job_data), .room(job_room),
      .pop_valid(q_valid), .pop_data(q_data), .pop(q_pop));

   wc3_back u_back (
      .clock, .reset,
      .coef_top(top_ff), .coef_mid(mid_ff), .coef_bot(bot_ff),
      .job_valid(q_valid), .job_data(q_data), .job_pop(q_pop),
      .rsp_valid, .rsp_stall, .rsp_data);

   // A frame end result must also be a row end.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.frame_end || rsp_data.row_end))
      else $error("frame_end without row_end");
   // A stalled result must stay put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");
   // The queue never pops when empty.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("queue underflow");
endmodule
